[rtl/core/utf8d_pkg.sv]
// Shared types, constants and helper functions of the UTF-8 byte stream decoder.
package utf8d_pkg;

   // Field widths
   localparam int ByteWidth      = 8;
   localparam int CodeUnitWidth  = 16;
   localparam int PayloadWidth   = 7;
   localparam int ContBits       = 6;
   localparam int LeftWidth      = 3;
   localparam int OnesWidth      = 4;
   localparam int UnitWidthDflt  = 16;

   // Sequence limits
   localparam logic [LeftWidth-1:0] MaxExtra = 3'd6;

   // Decoupling queue depth
   localparam int QueueDepth     = 2;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   // Work orders from the classifier to the accumulator
   typedef enum logic [1:0] {
      OP_EMIT       = 2'd0,   // payload is the result, accumulator untouched
      OP_LOAD       = 2'd1,   // lead byte: load payload into accumulator
      OP_SHIFT      = 2'd2,   // continuation: shift in six bits
      OP_SHIFT_EMIT = 2'd3    // last continuation: shift in and emit
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [PayloadWidth-1:0] payload;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Count of leading one bits of a byte, 0 to 8
   function automatic logic [OnesWidth-1:0] lead_ones(input logic [ByteWidth-1:0] b);
      logic [OnesWidth-1:0] n;
      logic                 run;
      n   = '0;
      run = 1'b1;
      for (int i = ByteWidth - 1; i >= 0; i--) begin
         run = run & b[i];
         n   = n + OnesWidth'(run);
      end
      return n;
   endfunction

   // Bits of a lead byte below its first zero bit
   function automatic logic [PayloadWidth-1:0] lead_payload(
      input logic [ByteWidth-1:0] b,
      input logic [OnesWidth-1:0] n
   );
      logic [PayloadWidth-1:0] p;
      p = '0;
      for (int i = 0; i < PayloadWidth; i++) begin
         if (OnesWidth'(i) + n < OnesWidth'(PayloadWidth)) begin
            p[i] = b[i];
         end
      end
      return p;
   endfunction

endpackage

[rtl/core/utf8d_front.sv]
// Classifier: accepts bytes, tracks open sequences and issues accumulator ops.
module utf8d_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [utf8d_pkg::ByteWidth-1:0]    req_byte,
   input  utf8d_pkg::queue_status_type        q_status,
   output logic                               push,
   output utf8d_pkg::q_entry_type             push_entry
);

   logic [utf8d_pkg::LeftWidth-1:0] bytes_left_ff;
   logic [utf8d_pkg::LeftWidth-1:0] bytes_left_in;
   logic [utf8d_pkg::OnesWidth-1:0] ones;
   logic [utf8d_pkg::LeftWidth-1:0] extra;
   logic                            accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   // Lead byte decode
   always_comb begin
      ones = utf8d_pkg::lead_ones(req_byte);
      if (ones > utf8d_pkg::OnesWidth'(utf8d_pkg::MaxExtra)) begin
         extra = utf8d_pkg::MaxExtra;
      end else if (ones == '0) begin
         extra = '0;
      end else begin
         extra = utf8d_pkg::LeftWidth'(ones - 1'b1);
      end
   end

   // Classification of the current byte
   always_comb begin
      bytes_left_in      = bytes_left_ff;
      push_entry.op      = utf8d_pkg::OP_EMIT;
      push_entry.payload = '0;
      if (bytes_left_ff != '0) begin
         bytes_left_in      = bytes_left_ff - 1'b1;
         push_entry.payload = {1'b0, req_byte[utf8d_pkg::ContBits-1:0]};
         push_entry.op      = (bytes_left_ff == 3'd1) ? utf8d_pkg::OP_SHIFT_EMIT
                                                      : utf8d_pkg::OP_SHIFT;
      end else if (!req_byte[utf8d_pkg::ByteWidth-1]) begin
         // plain ASCII goes straight out
         push_entry.payload = req_byte[utf8d_pkg::PayloadWidth-1:0];
      end else begin
         push_entry.payload = utf8d_pkg::lead_payload(req_byte, ones);
         if (extra != '0) begin
            push_entry.op = utf8d_pkg::OP_LOAD;
            bytes_left_in = extra;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

[rtl/core/utf8d_queue.sv]
// Short register queue between classifier and accumulator.
module utf8d_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  utf8d_pkg::q_entry_type       push_entry,
   input  logic                         pop,
   output utf8d_pkg::q_entry_type       pop_entry,
   output utf8d_pkg::queue_status_type  status
);

   utf8d_pkg::q_entry_type                   slot_ff [utf8d_pkg::QueueDepth];
   logic [utf8d_pkg::QueuePtrWidth-1:0]      wr_ptr_ff;
   logic [utf8d_pkg::QueuePtrWidth-1:0]      rd_ptr_ff;
   logic [utf8d_pkg::QueueCntWidth-1:0]      count_ff;
   logic [utf8d_pkg::QueueCntWidth-1:0]      count_in;

   assign status.full      = (count_ff == utf8d_pkg::QueueCntWidth'(utf8d_pkg::QueueDepth));
   assign status.not_empty = (count_ff != '0);
   assign pop_entry        = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == utf8d_pkg::QueuePtrWidth'(utf8d_pkg::QueueDepth - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == utf8d_pkg::QueuePtrWidth'(utf8d_pkg::QueueDepth - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/utf8d_back.sv]
// Accumulator: executes queued ops and holds the result in an output register.
module utf8d_back #(
   parameter int UNIT_WIDTH = utf8d_pkg::UnitWidthDflt
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  utf8d_pkg::queue_status_type           q_status,
   input  utf8d_pkg::q_entry_type                pop_entry,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [utf8d_pkg::CodeUnitWidth-1:0]   rsp_code_unit
);

   logic [UNIT_WIDTH-1:0]                  accum_ff;
   logic [UNIT_WIDTH-1:0]                  accum_in;
   logic [UNIT_WIDTH-1:0]                  shifted;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [utf8d_pkg::CodeUnitWidth-1:0]    rsp_data_ff;
   logic [utf8d_pkg::CodeUnitWidth-1:0]    rsp_data_in;

   // Take the next op whenever the output register is free or draining
   assign pop     = q_status.not_empty && (!rsp_valid_ff || rsp_tready);
   assign shifted = {accum_ff[UNIT_WIDTH-utf8d_pkg::ContBits-1:0],
                     pop_entry.payload[utf8d_pkg::ContBits-1:0]};

   always_comb begin
      accum_in     = accum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pop) begin
         case (pop_entry.op)
            utf8d_pkg::OP_EMIT: begin
               rsp_data_in  = utf8d_pkg::CodeUnitWidth'(pop_entry.payload);
               rsp_valid_in = 1'b1;
            end
            utf8d_pkg::OP_LOAD: begin
               accum_in = UNIT_WIDTH'(pop_entry.payload);
            end
            utf8d_pkg::OP_SHIFT: begin
               accum_in = shifted;
            end
            utf8d_pkg::OP_SHIFT_EMIT: begin
               accum_in     = shifted;
               rsp_data_in  = shifted[utf8d_pkg::CodeUnitWidth-1:0];
               rsp_valid_in = 1'b1;
            end
            default: begin
               accum_in = accum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      accum_ff    <= accum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_code_unit = rsp_data_ff;

endmodule

[rtl/core/utf8_byte_stream_decoder.sv]
// Top level of the UTF-8 byte stream decoder.
// Takes one byte per transaction and returns one 16-bit code unit for each
// ASCII byte, stray continuation byte or completed multi-byte sequence;
// lead and inner continuation bytes return nothing. One byte is accepted
// every clock while the queue has room: the classifier at the input and
// the accumulator at the output are separated by a two-entry queue. A
// completing byte passes through the queue and then the output register.
// The accumulator is UNIT_WIDTH bits wide and wraps; the result carries
// its low 16 bits. The input stalls only when the queue is full because
// results are not being taken.
module utf8_byte_stream_decoder #(
   parameter int UNIT_WIDTH = utf8d_pkg::UnitWidthDflt
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [15:0] code_unit
);

   utf8d_pkg::queue_status_type q_status;
   utf8d_pkg::q_entry_type      push_entry;
   utf8d_pkg::q_entry_type      pop_entry;
   logic                        push;
   logic                        pop;

   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   utf8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   utf8d_back #(
      .UNIT_WIDTH (UNIT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_code_unit (rsp_tdata)
   );

endmodule

[rtl/core/utf8d_checker.sv]
// Port-level checker for the UTF-8 byte stream decoder, with its bind.
module utf8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [31:0] in_cnt_ff;
   logic [31:0] out_cnt_ff;

   // Transaction counters on both sides
   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_cnt_ff <= in_cnt_ff + 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            out_cnt_ff <= out_cnt_ff + 1'b1;
         end
      end
   end

   // No result is left over after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Every result is owed to an accepted byte
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> in_cnt_ff != out_cnt_ff)
      else $error("result without an outstanding byte");

   // An ASCII first byte after reset comes out through the queue and the output register
   a_ascii_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tdata[7] && !rsp_tvalid
      && in_cnt_ff == out_cnt_ff && $past(in_cnt_ff == out_cnt_ff)
      && $past(in_cnt_ff) == in_cnt_ff && in_cnt_ff == 32'd0
      |=> ##1 rsp_tvalid)
      else $error("ASCII byte not returned in time");

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_utf8d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/utf8_byte_stream_decoder_checker.sv]
// Checker for the UTF-8 byte stream decoder: predicts code units and compares them.
module utf8_byte_stream_decoder_checker #(
   parameter int UNIT_WIDTH = utf8d_pkg::UnitWidthDflt
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // [15:0] code_unit
   output int          error_count,
   output int          pending_units
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AsciiLimit = 8'h80;

   // Decoder state as the block should hold it
   logic [UNIT_WIDTH-1:0]               partial_unit;
   logic [utf8d_pkg::LeftWidth-1:0]     cont_left;

   // Code units owed by the block, oldest first
   logic [utf8d_pkg::CodeUnitWidth-1:0] code_units_due[$];

   // Advance the decoder by one byte; returns 1 when a code unit completes
   function automatic bit decode_byte(input logic [utf8d_pkg::ByteWidth-1:0] b,
                                      output logic [utf8d_pkg::CodeUnitWidth-1:0] unit);
      int ones;
      int extra;
      int payload;
      unit = '0;
      if (cont_left != '0) begin
         // any byte continues an open sequence, prefix unchecked
         partial_unit = (partial_unit << utf8d_pkg::ContBits)
                        | UNIT_WIDTH'(b[utf8d_pkg::ContBits-1:0]);
         cont_left    = cont_left - 1'b1;
         unit         = partial_unit[utf8d_pkg::CodeUnitWidth-1:0];
         return cont_left == '0;
      end
      if (int'(b) < AsciiLimit) begin
         unit = utf8d_pkg::CodeUnitWidth'(b);
         return 1'b1;
      end
      ones = 0;
      while (ones < utf8d_pkg::ByteWidth && b[utf8d_pkg::ByteWidth-1-ones]) ones++;
      extra = ones - 1;
      if (extra > int'(utf8d_pkg::MaxExtra)) extra = int'(utf8d_pkg::MaxExtra);
      payload = (ones < utf8d_pkg::PayloadWidth)
                ? (int'(b) & ((1 << (utf8d_pkg::PayloadWidth - ones)) - 1)) : 0;
      partial_unit = UNIT_WIDTH'(payload);
      if (extra == 0) begin
         // stray continuation byte stands alone
         unit = partial_unit[utf8d_pkg::CodeUnitWidth-1:0];
         return 1'b1;
      end
      cont_left = utf8d_pkg::LeftWidth'(extra);
      return 1'b0;
   endfunction

   // Compare results first, then predict from the accepted byte
   always @(posedge clock) begin
      logic [utf8d_pkg::CodeUnitWidth-1:0] due;
      logic [utf8d_pkg::CodeUnitWidth-1:0] unit;
      int                                  errs;
      errs = 0;
      if (reset) begin
         partial_unit = '0;
         cont_left    = '0;
         code_units_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (code_units_due.size() == 0) begin
               $error("code_unit: unexpected transaction, expected none, actual 0x%04h",
                      rsp_tdata);
               errs++;
            end else begin
               due = code_units_due.pop_front();
               if (rsp_tdata !== due) begin
                  $error("code_unit: expected 0x%04h, actual 0x%04h", due, rsp_tdata);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_byte(req_tdata, unit)) code_units_due.push_back(unit);
         end
      end
      error_count   <= error_count + errs;
      pending_units <= code_units_due.size();
   end

   initial begin
      error_count   = 0;
      pending_units = 0;
   end

endmodule

[tb/tb_top.sv]
// Testbench top of the UTF-8 byte stream decoder: stimulus, flow control and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBytes = 1450;
   localparam int CycleLimit  = 200000;
   localparam int HoldAfter   = 400;
   localparam int HoldCycles  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] code_unit

   int          error_count;
   int          pending_units;
   int          bytes_sent = 0;
   int          cycle_count;

   logic [7:0]  text_bytes[$];

   utf8_byte_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   utf8_byte_stream_decoder_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_units (pending_units)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build the byte stream: mostly well-formed text, some noise
   task automatic build_text();
      logic [7:0] lead;
      logic [7:0] cont;
      int         ones;
      int         conts;
      int         pick;
      // ASCII extremes, stray continuations, 2/3/4-byte sequences,
      // six-continuation leads with unchecked and wrapping continuations
      text_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF,
                     8'hC2, 8'hA9,
                     8'hEF, 8'hBF, 8'hBD,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'hFF, 8'h3F, 8'hC0, 8'h7F, 8'hFF, 8'h80, 8'hBF,
                     8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
      while (text_bytes.size() < RandomBytes + 27) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            text_bytes.push_back(8'($urandom_range(0, 8'h7F)));
         end else if (pick < 85) begin
            pick = $urandom_range(0, 99);
            ones = (pick < 40) ? 2 : (pick < 65) ? 3 : (pick < 82) ? 4
                   : $urandom_range(5, 8);
            lead  = (8'hFF << (8 - ones)) | (8'($urandom) & (8'hFF >> (ones + 1)));
            conts = (ones - 1 > 6) ? 6 : ones - 1;
            text_bytes.push_back(lead);
            repeat (conts) begin
               // now and then a continuation with a bad prefix
               cont = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : (8'h80 | 8'($urandom_range(0, 63)));
               text_bytes.push_back(cont);
            end
         end else begin
            text_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // Stall pattern of the result side, with one long hold-off
   initial begin
      int  mode;
      int  span;
      bit  held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && bytes_sent >= HoldAfter) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         repeat (span) begin
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = $urandom_range(0, 1);
               2: rsp_tready = ($urandom_range(0, 5) == 0);
               default: rsp_tready = ~rsp_tready;
            endcase
            @(negedge clock);
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[utf8_byte_stream_decoder] ERROR");
      $finish;
   end

   // Reset, then send the stream in bursts with random gaps
   initial begin
      int idx;
      int burst;
      int gap;
      int mode;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      build_text();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idx = 0;
      while (idx < text_bytes.size()) begin
         mode = $urandom_range(0, 2);
         case (mode)
            0: begin
               burst = $urandom_range(1, 4);
               gap   = $urandom_range(1, 5);
            end
            1: begin
               burst = $urandom_range(5, 30);
               gap   = $urandom_range(0, 3);
            end
            default: begin
               burst = $urandom_range(50, 150);
               gap   = 0;
            end
         endcase
         for (int k = 0; k < burst && idx < text_bytes.size(); k++) begin
            req_tvalid = 1'b1;
            req_tdata  = text_bytes[idx];
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            idx++;
            bytes_sent = idx;
            @(negedge clock);
         end
         if (gap > 0) begin
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid = 1'b0;

      // Drain outstanding code units, then allow for the pipeline latency
      while (pending_units != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[utf8_byte_stream_decoder] OK");
      end else begin
         $display("[utf8_byte_stream_decoder] ERROR");
      end
      $finish;
   end

endmodule

[utf8_byte_stream_decoder.f]
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_queue.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_byte_stream_decoder.sv
rtl/core/utf8d_checker.sv
tb/utf8_byte_stream_decoder_checker.sv
tb/tb_top.sv
